// ----- sv/assert_macros.svh -----
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in any cycle implies another in the next cycle
`define BFA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/bfa_pkg.sv -----
// shared types and constants of the best-fit block allocator
`default_nettype none
package bfa_pkg;
	localparam int unsigned MaxBlocksDef = 64;
	localparam int unsigned HeaderBytes = 8;
	localparam int unsigned RegionMax = 65536;

	localparam logic [15:0] Hdr16 = 16'(HeaderBytes);
	localparam logic [16:0] Hdr17 = 17'(HeaderBytes);
	localparam logic [16:0] RegionMax17 = 17'(RegionMax);
	localparam logic [15:0] InitPayload = 16'(RegionMax - HeaderBytes);

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NOFIT = 2'd1;
	localparam logic [1:0] STATUS_BADFREE = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef struct packed {
		logic [15:0] off;
		logic [15:0] pay;
		logic busy;
	} entry_t;

	typedef struct packed {
		logic init;
		logic load;
		logic scan;
		logic plan;
		logic move_rd;
		logic move_wr;
		logic fix_a;
		logic fix_b;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic move_left;
		logic out_full;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- sv/bfa_datapath.sv -----
// block table memory, scan, move engine and result register
`default_nettype none
`include "assert_macros.svh"
module bfa_datapath #(
	parameter int MAX_BLOCKS = bfa_pkg::MaxBlocksDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bfa_pkg::ctl_cmd_t cmd,
	output bfa_pkg::dp_stat_t stat,
	input wire logic cfg_we,
	input wire logic [16:0] cfg_data,
	input wire logic in_cmd,
	input wire logic [15:0] in_req,
	input wire logic [15:0] in_off,
	input wire logic m_tready,
	output logic out_valid,
	output logic [1:0] out_status,
	output logic [15:0] out_offset
);
	import bfa_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] CountMax = CW'(MAX_BLOCKS);

	entry_t mem [MAX_BLOCKS];
	entry_t rd_q;

	logic [CW-1:0] count_q, new_count_q;
	logic [15:0] init_pay_q;
	logic op_q;
	logic [16:0] size_q;
	logic [15:0] foff_q;
	logic [CW-1:0] ptr_q;
	logic rv_s1;
	logic [AW-1:0] ridx_s1;
	logic found_q, has_next_q;
	logic [AW-1:0] idx_q;
	logic [15:0] diff_q;
	entry_t cur_q, prv_q, nxt_q, last_q;

	logic [1:0] res_status_q;
	logic [15:0] res_off_q;
	logic fa_en_q, fb_en_q;
	logic [AW-1:0] fa_addr_q, fb_addr_q;
	entry_t fa_data_q, fb_data_q;
	logic [AW-1:0] mv_src_q, mv_dst_q;
	logic [CW-1:0] mv_left_q;
	logic mv_up_q;
	logic out_valid_q;
	logic [1:0] out_status_q;
	logic [15:0] out_off_q;

	// region register saturation and alignment
	logic [16:0] reg_sat, reg_al, reg_fin;
	logic [15:0] cfg_pay;
	always_comb begin
		reg_sat = (cfg_data > RegionMax17) ? RegionMax17 : cfg_data;
		reg_al = {reg_sat[16:2], 2'b00};
		reg_fin = (reg_al < Hdr17) ? Hdr17 : reg_al;
		cfg_pay = 16'(reg_fin - Hdr17);
	end

	// scan compare on the returning word
	logic e_fits, take, e_match;
	logic [15:0] e_diff;
	always_comb begin
		e_fits = !rd_q.busy && ({1'b0, rd_q.pay} >= size_q);
		e_diff = 16'({1'b0, rd_q.pay} - size_q);
		take = e_fits && (!found_q || e_diff <= diff_q);
		e_match = rd_q.off == foff_q;
	end

	// decision after the scan
	logic [1:0] p_status;
	logic [15:0] p_off;
	logic p_fa_en, p_fb_en, p_up;
	logic [AW-1:0] p_fa_addr, p_fb_addr, p_src, p_dst;
	entry_t p_fa_data, p_fb_data;
	logic [CW-1:0] p_left, p_count, idx_c;
	logic split, mp, mn;
	always_comb begin
		idx_c = CW'(idx_q);
		split = (diff_q >= Hdr16) && (count_q < CountMax);
		mp = (idx_q != '0) && !prv_q.busy;
		mn = has_next_q && !nxt_q.busy;
		p_status = STATUS_OK;
		p_off = '0;
		p_fa_en = 1'b0;
		p_fb_en = 1'b0;
		p_up = 1'b0;
		p_fa_addr = idx_q;
		p_fb_addr = idx_q;
		p_fa_data = cur_q;
		p_fb_data = cur_q;
		p_src = idx_q;
		p_dst = idx_q;
		p_left = '0;
		p_count = count_q;
		if (op_q == CMD_ALLOC) begin
			if (!found_q) begin
				p_status = STATUS_NOFIT;
			end else begin
				p_off = cur_q.off;
				p_fb_en = 1'b1;
				p_fb_data = '{off: cur_q.off, pay: cur_q.pay, busy: 1'b1};
				if (split) begin
					p_up = 1'b1;
					p_src = AW'(count_q - 1'b1);
					p_dst = AW'(count_q);
					p_left = CW'(count_q - 1'b1 - idx_c);
					p_fa_en = 1'b1;
					p_fa_addr = AW'(idx_q + 1'b1);
					p_fa_data = '{off: 16'(cur_q.off + Hdr16 + size_q[15:0]),
						pay: 16'(diff_q - Hdr16), busy: 1'b0};
					p_fb_data.pay = size_q[15:0];
					p_count = CW'(count_q + 1'b1);
				end
			end
		end else begin
			if (!found_q || !cur_q.busy) begin
				p_status = STATUS_BADFREE;
			end else begin
				p_fa_en = 1'b1;
				if (mp && mn) begin
					p_fa_addr = AW'(idx_q - 1'b1);
					p_fa_data = '{off: prv_q.off,
						pay: 16'(prv_q.pay + cur_q.pay + nxt_q.pay + Hdr16 + Hdr16), busy: 1'b0};
					p_dst = idx_q;
					p_src = AW'(idx_q + 2'd2);
					p_left = CW'(count_q - idx_c - 2'd2);
					p_count = CW'(count_q - 2'd2);
				end else if (mp) begin
					p_fa_addr = AW'(idx_q - 1'b1);
					p_fa_data = '{off: prv_q.off, pay: 16'(prv_q.pay + cur_q.pay + Hdr16),
						busy: 1'b0};
					p_dst = idx_q;
					p_src = AW'(idx_q + 1'b1);
					p_left = CW'(count_q - idx_c - 1'b1);
					p_count = CW'(count_q - 1'b1);
				end else if (mn) begin
					p_fa_data = '{off: cur_q.off, pay: 16'(cur_q.pay + nxt_q.pay + Hdr16),
						busy: 1'b0};
					p_dst = AW'(idx_q + 1'b1);
					p_src = AW'(idx_q + 2'd2);
					p_left = CW'(count_q - idx_c - 2'd2);
					p_count = CW'(count_q - 1'b1);
				end else begin
					p_fa_data = '{off: cur_q.off, pay: cur_q.pay, busy: 1'b0};
				end
			end
		end
	end

	// memory port selection
	logic re, we;
	logic [AW-1:0] raddr, waddr;
	entry_t wdata;
	always_comb begin
		re = (cmd.scan && (ptr_q < count_q)) || cmd.move_rd;
		raddr = cmd.move_rd ? mv_src_q : ptr_q[AW-1:0];
		we = 1'b0;
		waddr = '0;
		wdata = '{off: 16'd0, pay: init_pay_q, busy: 1'b0};
		if (cmd.init) begin
			we = 1'b1;
		end else if (cmd.move_wr) begin
			we = 1'b1;
			waddr = mv_dst_q;
			wdata = rd_q;
		end else if (cmd.fix_a && fa_en_q) begin
			we = 1'b1;
			waddr = fa_addr_q;
			wdata = fa_data_q;
		end else if (cmd.fix_b && fb_en_q) begin
			we = 1'b1;
			waddr = fb_addr_q;
			wdata = fb_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			init_pay_q <= InitPayload;
			ptr_q <= '0;
			rv_s1 <= 1'b0;
			found_q <= 1'b0;
			has_next_q <= 1'b0;
			mv_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				init_pay_q <= cfg_pay;
			end
			if (cmd.init) begin
				count_q <= CW'(1);
			end
			if (cmd.load) begin
				ptr_q <= '0;
				rv_s1 <= 1'b0;
				found_q <= 1'b0;
				has_next_q <= 1'b0;
			end else if (cmd.scan) begin
				rv_s1 <= ptr_q < count_q;
				ridx_s1 <= ptr_q[AW-1:0];
				if (ptr_q < count_q) begin
					ptr_q <= CW'(ptr_q + 1'b1);
				end
				if (rv_s1) begin
					if (op_q == CMD_ALLOC) begin
						if (take) begin
							found_q <= 1'b1;
							diff_q <= e_diff;
							idx_q <= ridx_s1;
							cur_q <= rd_q;
						end
					end else begin
						last_q <= rd_q;
						if (!found_q && e_match) begin
							found_q <= 1'b1;
							idx_q <= ridx_s1;
							cur_q <= rd_q;
							prv_q <= last_q;
						end else if (found_q && ridx_s1 == AW'(idx_q + 1'b1)) begin
							nxt_q <= rd_q;
							has_next_q <= 1'b1;
						end
					end
				end
			end
			if (cmd.plan) begin
				res_status_q <= p_status;
				res_off_q <= p_off;
				fa_en_q <= p_fa_en;
				fa_addr_q <= p_fa_addr;
				fa_data_q <= p_fa_data;
				fb_en_q <= p_fb_en;
				fb_addr_q <= p_fb_addr;
				fb_data_q <= p_fb_data;
				mv_src_q <= p_src;
				mv_dst_q <= p_dst;
				mv_left_q <= p_left;
				mv_up_q <= p_up;
				new_count_q <= p_count;
			end
			if (cmd.move_wr) begin
				mv_left_q <= CW'(mv_left_q - 1'b1);
				if (mv_up_q) begin
					mv_src_q <= AW'(mv_src_q - 1'b1);
					mv_dst_q <= AW'(mv_dst_q - 1'b1);
				end else begin
					mv_src_q <= AW'(mv_src_q + 1'b1);
					mv_dst_q <= AW'(mv_dst_q + 1'b1);
				end
			end
			if (cmd.fix_b) begin
				count_q <= new_count_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_status_q <= res_status_q;
				out_off_q <= res_off_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// latch the word at acceptance
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_cmd;
			size_q <= ({1'b0, in_req} + 17'd3) & ~17'd3;
			foff_q <= in_off;
		end
	end

	always_comb begin
		stat.scan_done = !rv_s1 && (ptr_q == count_q);
		stat.move_left = mv_left_q != '0;
		stat.out_full = out_valid_q && !m_tready;
	end

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_offset = out_off_q;

	`BFA_ASSERT(a_count_range, (count_q != '0) && (count_q <= CountMax), "entry count out of range")
	`BFA_ASSERT(a_scan_ptr, !cmd.scan || (ptr_q <= count_q), "scan pointer past entry count")
	`BFA_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_q, "result not registered after load")
endmodule
`default_nettype wire

// ----- sv/bfa_ctrl.sv -----
// sequencing state machine of the allocator
`default_nettype none
`include "assert_macros.svh"
module bfa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic cfg_we,
	input wire bfa_pkg::dp_stat_t stat,
	output logic s_tready,
	output bfa_pkg::ctl_cmd_t cmd
);
	import bfa_pkg::*;

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_SCAN = 4'd2;
	localparam logic [3:0] ST_PLAN = 4'd3;
	localparam logic [3:0] ST_MRD = 4'd4;
	localparam logic [3:0] ST_MWR = 4'd5;
	localparam logic [3:0] ST_FIXA = 4'd6;
	localparam logic [3:0] ST_FIXB = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = !cfg_we;
				if (cfg_we) begin
					state_d = ST_INIT;
				end else if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d = ST_MRD;
			end
			ST_MRD: begin
				if (stat.move_left) begin
					cmd.move_rd = 1'b1;
					state_d = ST_MWR;
				end else begin
					state_d = ST_FIXA;
				end
			end
			ST_MWR: begin
				cmd.move_wr = 1'b1;
				state_d = ST_MRD;
			end
			ST_FIXA: begin
				cmd.fix_a = 1'b1;
				state_d = ST_FIXB;
			end
			ST_FIXB: begin
				cmd.fix_b = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	`BFA_ASSERT_NEXT(a_accept_scan, s_tvalid && s_tready, state_q == ST_SCAN, "accept did not start scan")
	`BFA_ASSERT_NEXT(a_cfg_init, cfg_we && (state_q == ST_IDLE), state_q == ST_INIT, "config write did not rebuild table")
	`BFA_ASSERT(a_one_write, !(cmd.init && (cmd.move_wr || cmd.fix_a || cmd.fix_b)), "init collides with table write")
endmodule
`default_nettype wire

// ----- sv/best_fit_block_allocator.sv -----
// top level of the best-fit block allocator
// Best-fit allocator over a table of up to MAX_BLOCKS blocks kept in address order in one
// single-port-write memory. One command is handled at a time: after the accept cycle the table
// is scanned one entry per cycle, then the decision is registered, then entries are shifted
// by a read state and a write state each for a split or merge, then the table is written back
// in the FIXA and FIXB states and the result is loaded once the output register is free or read.
// The table is rebuilt in the init state after reset or after a region_size write while idle.
// The next command is accepted while the previous result still waits in the output register.
`default_nettype none
module best_fit_block_allocator #(
	parameter int MAX_BLOCKS = bfa_pkg::MaxBlocksDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [16:0] cfg_data,  // region_size
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata,  // request_bytes, free_offset
	input wire logic [0:0] s_tuser,   // cmd
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata,      // block_offset
	output logic [1:0] m_tuser        // status
);
	import bfa_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bfa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.cfg_we(cfg_we),
		.stat(stat),
		.s_tready(s_tready),
		.cmd(cmd)
	);

	bfa_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_cmd(s_tuser[0]),
		.in_req(s_tdata[15:0]),
		.in_off(s_tdata[31:16]),
		.m_tready(m_tready),
		.out_valid(m_tvalid),
		.out_status(m_tuser),
		.out_offset(m_tdata)
	);
endmodule
`default_nettype wire
